// ----- rtl/ctg_pkg.sv -----
// ---------------------------------------------------------------------------
// ctg_pkg: shared types and constants for the color temperature gain block
// Widths, polynomial coefficients (signed Q32) and sequencer encodings.
// ---------------------------------------------------------------------------
package ctg_pkg;

   // pixel and level formats
   localparam int PIX_W               = 8;
   localparam int PIX_MAX             = 255;
   localparam int NUM_CHAN            = 3;
   localparam int SAT_LIMIT           = (PIX_MAX + 1) * PIX_MAX;
   localparam int LEVEL_INT_W         = 16;
   localparam int LEVEL_FRAC_BITS_DEF = 8;

   // temperature register
   localparam int                 KELVIN_W     = 16;
   localparam logic [KELVIN_W-1:0] KELVIN_RESET = 16'd6500;
   localparam logic [KELVIN_W-1:0] KELVIN_SPLIT = 16'd6500;
   localparam logic [KELVIN_W-1:0] BLUE_FLOOR   = 16'd1500;
   localparam logic [KELVIN_W-1:0] BLUE_CEIL    = 16'd7000;

   // polynomial arithmetic
   localparam int COEF_FRAC_W = 32;
   localparam int ACC_W       = 48;
   localparam int ACC_SPLIT   = ACC_W / 2;
   localparam int COEF_IDX_W  = 3;
   localparam int DIV_W       = 64;
   localparam int DIV_REM_W   = 7;
   localparam int DIVISOR     = 100;
   localparam int DIV_ROUND   = DIVISOR / 2;

   localparam longint Q32 = 64'sd4294967296;

   localparam longint RED_HI_C0 = (64'sd2 * Q32 + 64'sd100 / 2) / 64'sd100;
   localparam longint RED_HI_C1 = (64'sd4757143 * Q32 + 64'sd1000000 / 2) / 64'sd1000000;
   localparam longint RED_HI_C2 = (64'sd4797143 * Q32 + 64'sd10000 / 2) / 64'sd10000;

   localparam longint GRN_HI_C0 = (64'sd1 * Q32 + 64'sd100 / 2) / 64'sd100;
   localparam longint GRN_HI_C1 = (64'sd2502381 * Q32 + 64'sd1000000 / 2) / 64'sd1000000;
   localparam longint GRN_HI_C2 = (64'sd3693214 * Q32 + 64'sd10000 / 2) / 64'sd10000;

   localparam longint GRN_LO_C0 =
      (64'sd1430717 * Q32 + 64'sd1000000000 / 2) / 64'sd1000000000;
   localparam longint GRN_LO_C1 =
      (64'sd2250017 * Q32 + 64'sd10000000 / 2) / 64'sd10000000;
   localparam longint GRN_LO_C2 = (64'sd1321698 * Q32 + 64'sd100000 / 2) / 64'sd100000;
   localparam longint GRN_LO_C3 = (64'sd5034577 * Q32 + 64'sd100000 / 2) / 64'sd100000;

   localparam longint BLU_C0 =
      (64'sd4820513 * Q32 + 64'sd1000000000000 / 2) / 64'sd1000000000000;
   localparam longint BLU_C1 =
      (64'sd1048834 * Q32 + 64'sd1000000000 / 2) / 64'sd1000000000;
   localparam longint BLU_C2 =
      (64'sd8684615 * Q32 + 64'sd100000000 / 2) / 64'sd100000000;
   localparam longint BLU_C3 = (64'sd3321611 * Q32 + 64'sd1000000 / 2) / 64'sd1000000;
   localparam longint BLU_C4 = (64'sd510587 * Q32 + 64'sd10000 / 2) / 64'sd10000;
   localparam longint BLU_C5 = (64'sd2601294 * Q32 + 64'sd10000 / 2) / 64'sd10000;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_START,
      SEQ_MUL_LO,
      SEQ_MUL_HI,
      SEQ_PREP,
      SEQ_DIV,
      SEQ_ADD,
      SEQ_STORE
   } seq_state_type;

   typedef enum logic [1:0] {
      JOB_RED,
      JOB_GREEN,
      JOB_BLUE
   } job_type;

   typedef enum logic [1:0] {
      POLY_RED_HI,
      POLY_GREEN_HI,
      POLY_GREEN_LO,
      POLY_BLUE_MID
   } poly_type;

   typedef logic signed [ACC_W-1:0] coef_type;

   // coefficient table, highest power first
   function automatic coef_type poly_coef(poly_type poly, logic [COEF_IDX_W-1:0] idx);
      longint c;
      c = 0;
      case (poly)
         POLY_RED_HI: begin
            case (idx)
               3'd0:    c = RED_HI_C0;
               3'd1:    c = -RED_HI_C1;
               3'd2:    c = RED_HI_C2;
               default: c = 0;
            endcase
         end
         POLY_GREEN_HI: begin
            case (idx)
               3'd0:    c = GRN_HI_C0;
               3'd1:    c = -GRN_HI_C1;
               3'd2:    c = GRN_HI_C2;
               default: c = 0;
            endcase
         end
         POLY_GREEN_LO: begin
            case (idx)
               3'd0:    c = GRN_LO_C0;
               3'd1:    c = -GRN_LO_C1;
               3'd2:    c = GRN_LO_C2;
               3'd3:    c = -GRN_LO_C3;
               default: c = 0;
            endcase
         end
         POLY_BLUE_MID: begin
            case (idx)
               3'd0:    c = -BLU_C0;
               3'd1:    c = BLU_C1;
               3'd2:    c = -BLU_C2;
               3'd3:    c = BLU_C3;
               3'd4:    c = -BLU_C4;
               3'd5:    c = BLU_C5;
               default: c = 0;
            endcase
         end
         default: c = 0;
      endcase
      return coef_type'(c);
   endfunction

   function automatic logic [COEF_IDX_W-1:0] poly_last(poly_type poly);
      logic [COEF_IDX_W-1:0] n;
      case (poly)
         POLY_RED_HI:   n = 3'd2;
         POLY_GREEN_HI: n = 3'd2;
         POLY_GREEN_LO: n = 3'd3;
         POLY_BLUE_MID: n = 3'd5;
         default:       n = 3'd2;
      endcase
      return n;
   endfunction

endpackage

// ----- rtl/ctg_div100.sv -----
// ---------------------------------------------------------------------------
// ctg_div100: divider by one hundred
// Long division on 16-bit digits, one quotient digit per cycle, each digit
// found by reciprocal multiplication; unsigned dividend.
// ---------------------------------------------------------------------------
module ctg_div100 (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ctg_pkg::DIV_W-1:0]   dividend,
   output logic [ctg_pkg::DIV_W-1:0]   quotient,
   output logic                        done
);

   localparam int DIG_W    = 16;
   localparam int NUM_DIG  = ctg_pkg::DIV_W / DIG_W;
   localparam int CNT_W    = $clog2(NUM_DIG + 1);
   localparam int REM_W    = ctg_pkg::DIV_REM_W;
   localparam int PART_W   = REM_W + DIG_W;
   // floor(n / 100) = (n * RECIP) >> RECIP_SH holds for every partial value
   localparam int RECIP_SH = 30;
   localparam int RECIP_W  = 24;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << RECIP_SH) + ctg_pkg::DIVISOR - 1) / ctg_pkg::DIVISOR);
   localparam int MUL_W    = PART_W + RECIP_W;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [ctg_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [PART_W-1:0]         part;
   logic [MUL_W-1:0]          part_mul;
   logic [DIG_W-1:0]          digit;
   logic [PART_W-1:0]         digit_back;

   always_comb begin
      part       = {rem_ff, quo_ff[ctg_pkg::DIV_W-1 -: DIG_W]};
      part_mul   = MUL_W'(part) * MUL_W'(RECIP);
      digit      = part_mul[RECIP_SH +: DIG_W];
      digit_back = PART_W'(digit) * PART_W'(ctg_pkg::DIVISOR);
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (start) begin
         cnt_in = CNT_W'(NUM_DIG);
         quo_in = dividend;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         // shift dividend digits out the top, quotient digits in the bottom
         cnt_in = cnt_ff - 1'b1;
         quo_in = {quo_ff[ctg_pkg::DIV_W-DIG_W-1:0], digit};
         rem_in = REM_W'(part - digit_back);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient = quo_ff;
   assign done     = (cnt_ff == '0);

endmodule

// ----- rtl/ctg_level_seq.sv -----
// ---------------------------------------------------------------------------
// ctg_level_seq: channel level sequencer
// Holds the temperature register and derives the three levels as constants
// or by Horner evaluation on a shared split multiplier and serial divider.
// ---------------------------------------------------------------------------
module ctg_level_seq #(
   parameter int LEVEL_FRAC_BITS = ctg_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 start,
   input  logic [ctg_pkg::KELVIN_W-1:0]                         kelvin,
   output logic                                                 busy,
   output logic signed [ctg_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] red_level,
   output logic signed [ctg_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] green_level,
   output logic signed [ctg_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] blue_level
);

   localparam int LEVEL_W   = ctg_pkg::LEVEL_INT_W + LEVEL_FRAC_BITS;
   localparam int ACC_W     = ctg_pkg::ACC_W;
   localparam int DIV_W     = ctg_pkg::DIV_W;
   localparam int SPLIT     = ctg_pkg::ACC_SPLIT;
   localparam int KW        = ctg_pkg::KELVIN_W;
   localparam int LO_PROD_W = SPLIT + KW;
   localparam int HI_PROD_W = ACC_W - SPLIT + KW + 1;
   localparam int SHIFT     = ctg_pkg::COEF_FRAC_W - LEVEL_FRAC_BITS;
   localparam int IDX_W     = ctg_pkg::COEF_IDX_W;

   localparam logic signed [LEVEL_W-1:0] LEVEL_FULL =
      LEVEL_W'(ctg_pkg::PIX_MAX) << LEVEL_FRAC_BITS;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = {1'b0, {(LEVEL_W-1){1'b1}}};
   localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = {1'b1, {(LEVEL_W-1){1'b0}}};
   localparam logic [ACC_W:0]            ROUND_HALF = (ACC_W + 1)'(1) << (SHIFT - 1);

   ctg_pkg::seq_state_type state_ff, state_in;
   ctg_pkg::job_type       job_ff, job_in, job_next;
   ctg_pkg::poly_type      poly_ff, poly_in, poly_pick;
   logic [KW-1:0]          kelvin_ff, kelvin_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [DIV_W-1:0] prod_ff, prod_in;
   logic                   neg_ff, neg_in;
   logic signed [LEVEL_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   logic                   use_poly, job_last, div_start, div_done;
   logic signed [LEVEL_W-1:0] const_level, sat_level, level_val;
   logic                   level_we;
   logic [LO_PROD_W-1:0]   lo_prod;
   logic signed [HI_PROD_W-1:0] hi_prod;
   logic signed [DIV_W-1:0] hi_ext;
   logic [DIV_W-1:0]       div_dividend, div_quo;
   logic signed [ACC_W-1:0] quo_trunc, quo_signed;
   logic signed [ACC_W:0]  round_sum;
   logic signed [LEVEL_W:0] lvl_wide;

   // pick the formula for the channel at hand
   always_comb begin
      use_poly    = 1'b1;
      poly_pick   = ctg_pkg::POLY_GREEN_LO;
      const_level = LEVEL_FULL;
      case (job_ff)
         ctg_pkg::JOB_RED: begin
            if (kelvin_ff > ctg_pkg::KELVIN_SPLIT) begin
               poly_pick = ctg_pkg::POLY_RED_HI;
            end else begin
               use_poly = 1'b0;
            end
         end
         ctg_pkg::JOB_GREEN: begin
            poly_pick = (kelvin_ff > ctg_pkg::KELVIN_SPLIT) ? ctg_pkg::POLY_GREEN_HI
                                                           : ctg_pkg::POLY_GREEN_LO;
         end
         ctg_pkg::JOB_BLUE: begin
            if (kelvin_ff < ctg_pkg::BLUE_FLOOR) begin
               use_poly    = 1'b0;
               const_level = '0;
            end else if (kelvin_ff > ctg_pkg::BLUE_CEIL) begin
               use_poly = 1'b0;
            end else begin
               poly_pick = ctg_pkg::POLY_BLUE_MID;
            end
         end
         default: use_poly = 1'b0;
      endcase
   end

   always_comb begin
      job_last = (job_ff == ctg_pkg::JOB_BLUE);
      case (job_ff)
         ctg_pkg::JOB_RED:   job_next = ctg_pkg::JOB_GREEN;
         ctg_pkg::JOB_GREEN: job_next = ctg_pkg::JOB_BLUE;
         default:            job_next = ctg_pkg::JOB_RED;
      endcase
   end

   // split multiply: low half unsigned, high half signed, summed next cycle
   always_comb begin
      lo_prod = acc_ff[SPLIT-1:0] * kelvin_ff;
      hi_prod = $signed(acc_ff[ACC_W-1:SPLIT]) * $signed({1'b0, kelvin_ff});
      hi_ext  = {{(DIV_W-HI_PROD_W){hi_prod[HI_PROD_W-1]}}, hi_prod};
   end

   // floor division of a negative value: -(floor((-v + 99) / 100))
   assign div_dividend = prod_ff[DIV_W-1] ? (~prod_ff + DIV_W'(ctg_pkg::DIVISOR))
                                          : prod_ff;

   always_comb begin
      quo_trunc  = div_quo[ACC_W-1:0];
      quo_signed = neg_ff ? -quo_trunc : quo_trunc;
   end

   // round to the level format and clamp
   always_comb begin
      round_sum = {acc_ff[ACC_W-1], acc_ff} + ROUND_HALF;
      lvl_wide  = round_sum[ACC_W:SHIFT];
      if (lvl_wide[LEVEL_W] != lvl_wide[LEVEL_W-1]) begin
         sat_level = lvl_wide[LEVEL_W] ? LEVEL_MIN : LEVEL_MAX;
      end else begin
         sat_level = lvl_wide[LEVEL_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctg_pkg::SEQ_IDLE:   if (start) state_in = ctg_pkg::SEQ_START;
         ctg_pkg::SEQ_START: begin
            if (use_poly) begin
               state_in = ctg_pkg::SEQ_MUL_LO;
            end else begin
               state_in = job_last ? ctg_pkg::SEQ_IDLE : ctg_pkg::SEQ_START;
            end
         end
         ctg_pkg::SEQ_MUL_LO: state_in = ctg_pkg::SEQ_MUL_HI;
         ctg_pkg::SEQ_MUL_HI: state_in = ctg_pkg::SEQ_PREP;
         ctg_pkg::SEQ_PREP:   state_in = ctg_pkg::SEQ_DIV;
         ctg_pkg::SEQ_DIV:    if (div_done) state_in = ctg_pkg::SEQ_ADD;
         ctg_pkg::SEQ_ADD: begin
            state_in = (idx_ff == ctg_pkg::poly_last(poly_ff)) ? ctg_pkg::SEQ_STORE
                                                              : ctg_pkg::SEQ_MUL_LO;
         end
         ctg_pkg::SEQ_STORE:  state_in = job_last ? ctg_pkg::SEQ_IDLE : ctg_pkg::SEQ_START;
         default:             state_in = ctg_pkg::SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b1;
      div_start = 1'b0;
      level_we  = 1'b0;
      level_val = sat_level;
      case (state_ff)
         ctg_pkg::SEQ_IDLE:  busy = 1'b0;
         ctg_pkg::SEQ_START: begin
            level_we  = !use_poly;
            level_val = const_level;
         end
         ctg_pkg::SEQ_PREP:  div_start = 1'b1;
         ctg_pkg::SEQ_STORE: level_we = 1'b1;
         default:            busy = 1'b1;
      endcase
   end

   // datapath next values
   always_comb begin
      kelvin_in = kelvin_ff;
      job_in    = job_ff;
      poly_in   = poly_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      case (state_ff)
         ctg_pkg::SEQ_IDLE: begin
            if (start) begin
               kelvin_in = kelvin;
               job_in    = ctg_pkg::JOB_RED;
            end
         end
         ctg_pkg::SEQ_START: begin
            if (use_poly) begin
               poly_in = poly_pick;
               acc_in  = ctg_pkg::poly_coef(poly_pick, '0);
               idx_in  = IDX_W'(1);
            end else begin
               job_in = job_next;
            end
         end
         ctg_pkg::SEQ_MUL_LO: prod_in = DIV_W'(lo_prod);
         ctg_pkg::SEQ_MUL_HI: begin
            prod_in = prod_ff + (hi_ext <<< SPLIT) + DIV_W'(ctg_pkg::DIV_ROUND);
         end
         ctg_pkg::SEQ_PREP:   neg_in = prod_ff[DIV_W-1];
         ctg_pkg::SEQ_ADD: begin
            acc_in = quo_signed + ctg_pkg::poly_coef(poly_ff, idx_ff);
            idx_in = idx_ff + 1'b1;
         end
         ctg_pkg::SEQ_STORE:  job_in = job_next;
         default: ;
      endcase
      if (level_we) begin
         case (job_ff)
            ctg_pkg::JOB_RED:   red_in   = level_val;
            ctg_pkg::JOB_GREEN: green_in = level_val;
            default:            blue_in  = level_val;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // derive the reset temperature's levels right away
         state_ff  <= ctg_pkg::SEQ_START;
         job_ff    <= ctg_pkg::JOB_RED;
         kelvin_ff <= ctg_pkg::KELVIN_RESET;
         poly_ff   <= ctg_pkg::POLY_RED_HI;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         job_ff    <= job_in;
         kelvin_ff <= kelvin_in;
         poly_ff   <= poly_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   ctg_div100 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign red_level   = red_ff;
   assign green_level = green_ff;
   assign blue_level  = blue_ff;

endmodule

// ----- rtl/ctg_pixel_pipe.sv -----
// ---------------------------------------------------------------------------
// ctg_pixel_pipe: three-stage pixel scaling pipeline
// Input register, product register, result register; each channel is
// multiplied by its level, rounded, divided by 255 and saturated.
// ---------------------------------------------------------------------------
module ctg_pixel_pipe #(
   parameter int LEVEL_FRAC_BITS = ctg_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  hold,
   input  logic signed [ctg_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] red_level,
   input  logic signed [ctg_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] green_level,
   input  logic signed [ctg_pkg::LEVEL_INT_W+LEVEL_FRAC_BITS-1:0] blue_level,
   input  logic                                                  req_valid,
   output logic                                                  req_stall,
   input  logic [ctg_pkg::NUM_CHAN-1:0][ctg_pkg::PIX_W-1:0]      req_chan,
   output logic                                                  rsp_valid,
   input  logic                                                  rsp_stall,
   output logic [ctg_pkg::NUM_CHAN-1:0][ctg_pkg::PIX_W-1:0]      rsp_chan
);

   localparam int PW      = ctg_pkg::PIX_W;
   localparam int NC      = ctg_pkg::NUM_CHAN;
   localparam int LEVEL_W = ctg_pkg::LEVEL_INT_W + LEVEL_FRAC_BITS;
   localparam int PROD_W  = PW + LEVEL_W - 1;
   localparam int T_W     = PROD_W + 1 - LEVEL_FRAC_BITS;
   localparam int W2      = 2 * PW;
   localparam int M_W     = 3 * PW + 1;
   localparam logic [PROD_W:0] HALF =
      (PROD_W + 1)'(ctg_pkg::PIX_MAX) << (LEVEL_FRAC_BITS - 1);

   logic                 v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic                 ready1, ready2, ready3, accept, adv12, adv23, take;

   logic [NC-1:0][PW-1:0]     chan_ff, chan_in;
   logic [NC-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [NC-1:0][PW-1:0]     out_ff, out_in;

   logic signed [LEVEL_W-1:0] lvl     [NC];
   logic [LEVEL_W-2:0]        lvl_pos [NC];
   logic [PROD_W-1:0]         prod_c  [NC];
   logic [PROD_W:0]           rsum    [NC];
   logic [T_W-1:0]            t_val   [NC];
   logic [W2-1:0]             t16     [NC];
   logic [M_W-1:0]            m_val   [NC];
   logic [PW-1:0]             q0      [NC];
   logic [W2-1:0]             back    [NC];
   logic [W2-1:0]             r_val   [NC];
   logic [PW-1:0]             res_c   [NC];

   // handshake: a stage takes a request when it is empty or moving on
   always_comb begin
      ready3    = !v3_ff || !rsp_stall;
      adv23     = v2_ff && ready3;
      ready2    = !v2_ff || ready3;
      adv12     = v1_ff && ready2;
      ready1    = !v1_ff || ready2;
      req_stall = hold || !ready1;
      accept    = req_valid && !req_stall;
      take      = v3_ff && !rsp_stall;
      v1_in     = accept ? 1'b1 : (adv12 ? 1'b0 : v1_ff);
      v2_in     = adv12 ? 1'b1 : (adv23 ? 1'b0 : v2_ff);
      v3_in     = adv23 ? 1'b1 : (take ? 1'b0 : v3_ff);
   end

   assign lvl[0] = red_level;
   assign lvl[1] = green_level;
   assign lvl[2] = blue_level;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         // a level of zero or below gives black
         lvl_pos[c] = (!lvl[c][LEVEL_W-1] && lvl[c] != '0) ? lvl[c][LEVEL_W-2:0] : '0;
         prod_c[c]  = chan_ff[c] * lvl_pos[c];

         rsum[c]  = {1'b0, prod_ff[c]} + HALF;
         t_val[c] = rsum[c][PROD_W:LEVEL_FRAC_BITS];
         // divide by 255: estimate with t*257/65536, then one correction
         t16[c]   = t_val[c][W2-1:0];
         m_val[c] = {1'b0, t16[c], PW'(0)} + M_W'(t16[c]);
         q0[c]    = m_val[c][3*PW-1:W2];
         back[c]  = {q0[c], PW'(0)} - W2'(q0[c]);
         r_val[c] = t16[c] - back[c];
         if (t_val[c] >= T_W'(ctg_pkg::SAT_LIMIT)) begin
            res_c[c] = PW'(ctg_pkg::PIX_MAX);
         end else if (r_val[c] >= W2'(ctg_pkg::PIX_MAX)) begin
            res_c[c] = q0[c] + 1'b1;
         end else begin
            res_c[c] = q0[c];
         end

         chan_in[c] = accept ? req_chan[c] : chan_ff[c];
         prod_in[c] = adv12 ? prod_c[c] : prod_ff[c];
         out_in[c]  = adv23 ? res_c[c] : out_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp_chan  = out_ff;

endmodule

// ----- rtl/color_temperature_gain.sv -----
// ---------------------------------------------------------------------------
// color_temperature_gain: white balance gains from a lamp color temperature
// Scales each pixel's three channels by levels derived from lamp_kelvin.
// ---------------------------------------------------------------------------
// Pixels stream at one per clock unless rsp_stall or a level derivation
// holds them, through the input, product and result registers. Writing
// csr_lamp_kelvin starts the level derivation, which evaluates the
// polynomials term by term on one split multiplier and a divide-by-100 unit
// that yields sixteen quotient bits per cycle; a derivation also runs for
// the 6500 K reset value right after reset. While it runs req_stall is held
// high and csr_ready low.
module color_temperature_gain #(
   parameter int LEVEL_FRAC_BITS = ctg_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ctg_pkg::KELVIN_W-1:0]      csr_lamp_kelvin,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ctg_pkg::PIX_W-1:0]         req_chan_zero,
   input  logic [ctg_pkg::PIX_W-1:0]         req_chan_one,
   input  logic [ctg_pkg::PIX_W-1:0]         req_chan_two,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ctg_pkg::PIX_W-1:0]         rsp_out_zero,
   output logic [ctg_pkg::PIX_W-1:0]         rsp_out_one,
   output logic [ctg_pkg::PIX_W-1:0]         rsp_out_two
);

   localparam int LEVEL_W = ctg_pkg::LEVEL_INT_W + LEVEL_FRAC_BITS;

   logic                      seq_busy, csr_write;
   logic signed [LEVEL_W-1:0] red_level, green_level, blue_level;
   logic [ctg_pkg::NUM_CHAN-1:0][ctg_pkg::PIX_W-1:0] req_chan, rsp_chan;

   assign csr_ready = !seq_busy;
   assign csr_write = csr_valid && csr_ready;

   ctg_level_seq #(
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (csr_write),
      .kelvin      (csr_lamp_kelvin),
      .busy        (seq_busy),
      .red_level   (red_level),
      .green_level (green_level),
      .blue_level  (blue_level)
   );

   assign req_chan = {req_chan_two, req_chan_one, req_chan_zero};

   ctg_pixel_pipe #(
      .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .hold        (seq_busy),
      .red_level   (red_level),
      .green_level (green_level),
      .blue_level  (blue_level),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_chan    (req_chan),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_chan    (rsp_chan)
   );

   assign rsp_out_zero = rsp_chan[0];
   assign rsp_out_one  = rsp_chan[1];
   assign rsp_out_two  = rsp_chan[2];

   // no pixel enters while levels are being derived
   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      seq_busy |-> !(req_valid && !req_stall))
      else $error("pixel request accepted during level derivation");

   // a temperature write always launches a derivation
   a_csr_starts_seq: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> seq_busy)
      else $error("temperature write did not start level derivation");

   // a derivation blocks further temperature writes
   a_csr_blocked_busy: assert property (@(posedge clock) disable iff (reset)
      seq_busy |-> !csr_write)
      else $error("temperature write taken during level derivation");

endmodule
